// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold on every clock edge outside reset.
`define ASSERT_PROP(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
// Antecedent in a cycle implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Antecedent in a cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_PROP(label, clk, rstn, prop)
`define ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ----- sv/lbfrs_pkg.sv -----
// ---------------------------------------------------------------------------
// lbfrs_pkg
// Shared types and constants of the bracket field run statistics block.
// ---------------------------------------------------------------------------
package lbfrs_pkg;

    localparam int BYTE_WIDTH = 8;
    localparam int SKIP_WIDTH = 6;
    localparam int OUT_WIDTH  = 32;

    localparam logic [SKIP_WIDTH-1:0] SKIP_RESET = 6'd15;
    localparam logic [BYTE_WIDTH-1:0] CHAR_LBRACKET = 8'h5B;
    localparam logic [BYTE_WIDTH-1:0] CHAR_SPACE    = 8'h20;
    localparam logic [BYTE_WIDTH-1:0] CHAR_TAB      = 8'h09;
    localparam logic [BYTE_WIDTH-1:0] CHAR_CR       = 8'h0D;
    localparam logic [BYTE_WIDTH-1:0] CHAR_ZERO     = 8'h30;
    localparam logic [BYTE_WIDTH-1:0] CHAR_NINE     = 8'h39;

    // Parser phase within one record
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SKIP,
        PH_SPACE,
        PH_NUMBER
    } phase_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_RUN,
        ST_FINAL,
        ST_CLOSE,
        ST_START,
        ST_DIV,
        ST_LOAD
    } ctrl_state_t;

    typedef struct packed {
        logic byte_en;     // process the accepted byte
        logic final_take;  // close an open record at end of text
        logic close;       // close the final run
        logic div_start;   // launch average division
        logic load_out;    // load result register, clear statistics
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

// ----- sv/lbfrs_div.sv -----
// ---------------------------------------------------------------------------
// lbfrs_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module lbfrs_div #(
    parameter int WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic [WIDTH-1:0] quotient,
    output logic             busy,
    output logic             done
);

    localparam int CNT_WIDTH = $clog2(WIDTH + 1);

    logic [WIDTH-1:0]     quo_reg, quo_next;
    logic [WIDTH-1:0]     rem_reg, rem_next;
    logic [WIDTH-1:0]     dsr_reg, dsr_next;
    logic [CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [WIDTH:0]       shifted;
    logic                 ge;

    assign shifted = {rem_reg, quo_reg[WIDTH-1]};
    assign ge      = (shifted >= {1'b0, dsr_reg});

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNT_WIDTH'(WIDTH);
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            rem_next = ge ? WIDTH'(shifted - {1'b0, dsr_reg}) : shifted[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_WIDTH'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;
    assign done     = done_reg;

endmodule

// ----- sv/lbfrs_ctrl.sv -----
// ---------------------------------------------------------------------------
// lbfrs_ctrl
// Sequencer: byte streaming, end-of-text wrap-up, division, result load.
// ---------------------------------------------------------------------------
module lbfrs_ctrl
    import lbfrs_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    input  logic s_tlast,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_RUN: begin
                s_tready    = 1'b1;
                cmd.byte_en = s_tvalid;
                if (s_tvalid && s_tlast) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                cmd.final_take = 1'b1;
                state_next     = ST_CLOSE;
            end
            ST_CLOSE: begin
                cmd.close  = 1'b1;
                state_next = ST_START;
            end
            ST_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

endmodule

// ----- sv/lbfrs_dp.sv -----
// ---------------------------------------------------------------------------
// lbfrs_dp
// Parser, run statistics, average divider and result register.
// ---------------------------------------------------------------------------
module lbfrs_dp
    import lbfrs_pkg::*;
#(
    parameter int VALUE_WIDTH = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cmd_t                    cmd,
    output sts_t                    sts,
    input  logic                    cfg_wr_en,
    input  logic [SKIP_WIDTH-1:0]   cfg_wr_data,
    input  logic [BYTE_WIDTH-1:0]   text_byte,
    input  logic                    m_tready,
    output logic                    m_tvalid,
    output logic [2*OUT_WIDTH-1:0]  m_tdata,
    output logic                    m_tuser
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = '1;

    logic [SKIP_WIDTH-1:0]  skip_count_reg;
    phase_t                 phase_reg, phase_next;
    logic [SKIP_WIDTH-1:0]  skip_left_reg, skip_left_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic [VALUE_WIDTH-1:0] prev_reg, prev_next;
    logic                   have_reg, have_next;
    logic [COUNT_WIDTH-1:0] cur_reg, cur_next;
    logic [COUNT_WIDTH-1:0] longest_reg, longest_next;
    logic [COUNT_WIDTH-1:0] total_reg, total_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    logic [OUT_WIDTH-1:0]   avg_reg, max_reg;
    logic                   nrec_reg, m_valid_reg;

    logic                   is_space, is_digit, is_lbr;
    logic [VALUE_WIDTH+3:0] acc_x10;
    logic [VALUE_WIDTH+4:0] acc_sum;
    logic [VALUE_WIDTH-1:0] acc_sat;
    logic                   take, open, close_fire;
    logic [VALUE_WIDTH-1:0] take_val;
    logic [COUNT_WIDTH:0]   total_sum;

    logic [COUNT_WIDTH-1:0] quotient;
    logic                   div_busy, div_done;
    logic [OUT_WIDTH-1:0]   avg_sat, max_sat;

    // Byte classes
    assign is_space = (text_byte == CHAR_SPACE) ||
                      ((text_byte >= CHAR_TAB) && (text_byte <= CHAR_CR));
    assign is_digit = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
    assign is_lbr   = (text_byte == CHAR_LBRACKET);

    // acc * 10 + digit, saturating
    assign acc_x10 = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1);
    assign acc_sum = {1'b0, acc_x10} + (VALUE_WIDTH+5)'(text_byte[3:0]);
    assign acc_sat = (|acc_sum[VALUE_WIDTH+4:VALUE_WIDTH]) ? VALUE_MAX
                                                            : acc_sum[VALUE_WIDTH-1:0];

    // Parser
    always_comb begin
        phase_next     = phase_reg;
        skip_left_next = skip_left_reg;
        acc_next       = acc_reg;
        take           = 1'b0;
        take_val       = '0;
        open           = 1'b0;
        if (cmd.byte_en) begin
            case (phase_reg)
                PH_IDLE: begin
                    open = is_lbr;
                end
                PH_SKIP: begin
                    skip_left_next = skip_left_reg - 1'b1;
                    if (skip_left_reg == SKIP_WIDTH'(1)) begin
                        phase_next = PH_SPACE;
                    end
                end
                PH_SPACE: begin
                    if (is_digit) begin
                        acc_next   = VALUE_WIDTH'(text_byte[3:0]);
                        phase_next = PH_NUMBER;
                    end else if (!is_space) begin
                        take = 1'b1;
                        open = is_lbr;  // terminator is handled again
                    end
                end
                PH_NUMBER: begin
                    if (is_digit) begin
                        acc_next = acc_sat;
                    end else begin
                        take     = 1'b1;
                        take_val = acc_reg;
                        open     = is_lbr;
                    end
                end
                default: ;
            endcase
        end
        if (cmd.final_take) begin
            case (phase_reg)
                PH_SKIP, PH_SPACE: take = 1'b1;
                PH_NUMBER: begin
                    take     = 1'b1;
                    take_val = acc_reg;
                end
                default: ;
            endcase
        end
        if (take) begin
            acc_next   = '0;
            phase_next = PH_IDLE;
        end
        if (open) begin
            skip_left_next = skip_count_reg;
            acc_next       = '0;
            phase_next     = (skip_count_reg == '0) ? PH_SPACE : PH_SKIP;
        end
        if (cmd.load_out) begin
            phase_next     = PH_IDLE;
            skip_left_next = '0;
            acc_next       = '0;
        end
    end

    // Run statistics
    assign close_fire = have_reg && ((take && (take_val != prev_reg)) || cmd.close);
    assign total_sum  = {1'b0, total_reg} + {1'b0, cur_reg};

    always_comb begin
        prev_next    = prev_reg;
        have_next    = have_reg;
        cur_next     = cur_reg;
        longest_next = longest_reg;
        total_next   = total_reg;
        count_next   = count_reg;
        if (close_fire) begin
            if (cur_reg > longest_reg) begin
                longest_next = cur_reg;
            end
            total_next = total_sum[COUNT_WIDTH] ? COUNT_MAX : total_sum[COUNT_WIDTH-1:0];
            count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
        end
        if (take) begin
            if (have_reg && (take_val == prev_reg)) begin
                cur_next = (cur_reg == COUNT_MAX) ? cur_reg : cur_reg + 1'b1;
            end else begin
                cur_next = COUNT_WIDTH'(1);
            end
            have_next = 1'b1;
            prev_next = take_val;
        end
        if (cmd.load_out) begin
            prev_next    = '0;
            have_next    = 1'b0;
            cur_next     = '0;
            longest_next = '0;
            total_next   = '0;
            count_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_count_reg <= SKIP_RESET;
            phase_reg      <= PH_IDLE;
            skip_left_reg  <= '0;
            acc_reg        <= '0;
            prev_reg       <= '0;
            have_reg       <= 1'b0;
            cur_reg        <= '0;
            longest_reg    <= '0;
            total_reg      <= '0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                skip_count_reg <= cfg_wr_data;
            end
            phase_reg     <= phase_next;
            skip_left_reg <= skip_left_next;
            acc_reg       <= acc_next;
            prev_reg      <= prev_next;
            have_reg      <= have_next;
            cur_reg       <= cur_next;
            longest_reg   <= longest_next;
            total_reg     <= total_next;
            count_reg     <= count_next;
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (cmd.load_out) begin
            avg_reg  <= have_reg ? avg_sat : '0;
            max_reg  <= have_reg ? max_sat : '0;
            nrec_reg <= !have_reg;
        end
    end

    lbfrs_div #(
        .WIDTH (COUNT_WIDTH)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (total_reg),
        .divisor  (count_reg),
        .quotient (quotient),
        .busy     (div_busy),
        .done     (div_done)
    );

    // Clamp or zero-extend counts to the 32-bit result fields
    generate
        if (COUNT_WIDTH > OUT_WIDTH) begin : g_clamp
            assign avg_sat = (|quotient[COUNT_WIDTH-1:OUT_WIDTH]) ? '1
                                                                 : quotient[OUT_WIDTH-1:0];
            assign max_sat = (|longest_reg[COUNT_WIDTH-1:OUT_WIDTH]) ? '1
                                                                    : longest_reg[OUT_WIDTH-1:0];
        end else begin : g_extend
            assign avg_sat = OUT_WIDTH'(quotient);
            assign max_sat = OUT_WIDTH'(longest_reg);
        end
    endgenerate

    assign sts.div_busy = div_busy;
    assign sts.div_done = div_done;
    assign sts.out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {max_reg, avg_reg};
    assign m_tuser  = nrec_reg;

endmodule

// ----- sv/log_bracket_field_run_stats.sv -----
// ---------------------------------------------------------------------------
// log_bracket_field_run_stats
// Bracketed decimal field extraction with run-length statistics.
// ---------------------------------------------------------------------------
// Log text enters one byte per beat. Each '[' outside skipped bytes opens a
// record: cfg skip_count bytes are dropped, whitespace is skipped, then a
// decimal number is read (saturating at 2^VALUE_WIDTH-1; no digits reads as
// 0). The byte ending a number is parsed again, so a '[' there opens the next
// record. Runs of equal consecutive values are tracked. The tlast beat closes
// any open record and the final run, then one result beat carries the
// truncated mean run length and the longest run; tuser flags a text without
// records (data then zero). Statistics clear after each result. Rate: one byte
// per cycle while parsing; a tlast beat then holds s_tready low through the
// record close, the run close, the bit-serial divider (one quotient bit per
// cycle) and any wait for the result register to drain. skip_count may be
// written any time the block is idle; it is sampled at each opening '['.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module log_bracket_field_run_stats
    import lbfrs_pkg::*;
#(
    parameter int VALUE_WIDTH = 16,   // record value width, 4..32
    parameter int COUNT_WIDTH = 32    // run counter width, 8..48
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    // Configuration: skip_count
    input  logic                   cfg_wr_en,
    input  logic [SKIP_WIDTH-1:0]  cfg_wr_data,

    // Text input
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_WIDTH-1:0]  s_tdata,   // [7:0] text_byte
    input  logic                   s_tlast,   // end_of_text

    // Result output
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [2*OUT_WIDTH-1:0] m_tdata,   // [31:0] average_per_slot,
                                              // [63:32] maximum_per_slot
    output logic                   m_tuser    // [0] no_records
);

    cmd_t cmd;   // controller -> datapath
    sts_t sts;   // datapath -> controller

    lbfrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lbfrs_dp #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .text_byte   (s_tdata),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // No text beat is taken while the divider runs
    `ASSERT_IMPLY(a_no_accept_in_div, aclk, aresetn, sts.div_busy, !s_tready)
    // Wrap-up starts right after the tlast beat
    `ASSERT_NEXT(a_last_stalls, aclk, aresetn, s_tvalid && s_tready && s_tlast, !s_tready)
    // A new result only follows a finished division
    `ASSERT_IMPLY(a_result_after_div, aclk, aresetn, $rose(m_tvalid), $past(sts.div_done))
    // Empty text reports zero statistics
    `ASSERT_IMPLY(a_empty_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == '0)

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the bracketed log field run statistics block.
// ---------------------------------------------------------------------------
// Text bytes are streamed into the block. A tracker class follows the parser
// and the run statistics beat by beat and queues one expected summary for
// every tlast beat. Result beats are compared field by field against the
// oldest queued summary. The run is a short directed text set, followed by
// random texts over several skip_count settings and back-pressure profiles.
// ---------------------------------------------------------------------------
module testbench;
    import lbfrs_pkg::*;

    // Divider latency plus margin; used before skip_count writes and at the end
    localparam int DRAIN_CYCLES = 48;
    localparam int CYCLE_LIMIT  = 400000;
    // Per random segment: minimum beats and minimum summaries
    localparam int SEG_BEATS    = 140;
    localparam int SEG_RESULTS  = 1;
    localparam int NUM_SEGMENTS = 6;

    localparam logic [BYTE_WIDTH-1:0] CHAR_RBRACKET = 8'h5D;

    typedef struct {
        logic [OUT_WIDTH-1:0] mean_run;
        logic [OUT_WIDTH-1:0] longest;
        logic                 empty;
    } run_summary_t;

    // -----------------------------------------------------------------------
    // Tracker: parser state, run statistics and the queue of expected
    // summaries, one per tlast beat.
    // -----------------------------------------------------------------------
    class bracket_run_tracker;
        logic [SKIP_WIDTH-1:0] skip_cfg;
        phase_t                phase;
        logic [SKIP_WIDTH-1:0] skip_left;
        logic [15:0]           number_acc;
        logic [15:0]           last_value;
        bit                    seen_value;
        logic [31:0]           run_len;
        logic [31:0]           longest_run;
        logic [31:0]           total_len;
        logic [31:0]           run_cnt;
        run_summary_t          summary_q[$];
        int                    mismatches;
        int                    summaries_seen;

        function new();
            skip_cfg       = SKIP_RESET;
            mismatches     = 0;
            summaries_seen = 0;
            clear_stats();
        endfunction

        function void clear_stats();
            phase       = PH_IDLE;
            skip_left   = '0;
            number_acc  = '0;
            last_value  = '0;
            seen_value  = 1'b0;
            run_len     = '0;
            longest_run = '0;
            total_len   = '0;
            run_cnt     = '0;
        endfunction

        function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
            logic [32:0] sum;
            sum = {1'b0, a} + {1'b0, b};
            return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        endfunction

        function bit is_space(logic [7:0] b);
            return (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);
        endfunction

        function bit is_digit(logic [7:0] b);
            return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
        endfunction

        function void close_run();
            if (run_len > longest_run)
                longest_run = run_len;
            total_len = sat_add(total_len, run_len);
            run_cnt   = sat_add(run_cnt, 32'd1);
        endfunction

        function void take_record(logic [15:0] v);
            if (!seen_value) begin
                run_len    = 32'd1;
                seen_value = 1'b1;
            end else if (v == last_value) begin
                run_len = sat_add(run_len, 32'd1);
            end else begin
                close_run();
                run_len = 32'd1;
            end
            last_value = v;
            phase      = PH_IDLE;
            number_acc = '0;
        endfunction

        // Returns 1 when the byte has to go through the parser again
        function bit parse_byte(logic [7:0] b);
            logic [19:0] widened;
            case (phase)
                PH_IDLE: begin
                    if (b == CHAR_LBRACKET) begin
                        skip_left  = skip_cfg;
                        number_acc = '0;
                        phase      = (skip_cfg == 0) ? PH_SPACE : PH_SKIP;
                    end
                    return 1'b0;
                end
                PH_SKIP: begin
                    skip_left = skip_left - 1'b1;
                    if (skip_left == 0)
                        phase = PH_SPACE;
                    return 1'b0;
                end
                PH_SPACE: begin
                    if (is_space(b))
                        return 1'b0;
                    if (is_digit(b)) begin
                        number_acc = 16'(b - CHAR_ZERO);
                        phase      = PH_NUMBER;
                        return 1'b0;
                    end
                    take_record('0);
                    return 1'b1;
                end
                default: begin
                    if (is_digit(b)) begin
                        widened    = number_acc * 20'd10 + (b - CHAR_ZERO);
                        number_acc = (widened > 20'hFFFF) ? 16'hFFFF : widened[15:0];
                        return 1'b0;
                    end
                    take_record(number_acc);
                    return 1'b1;
                end
            endcase
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            run_summary_t s;
            if (parse_byte(b))
                void'(parse_byte(b));
            if (!last)
                return;
            // text ended inside a record: close it with what was read
            if (phase == PH_SKIP || phase == PH_SPACE)
                take_record('0);
            else if (phase == PH_NUMBER)
                take_record(number_acc);
            s.empty    = !seen_value;
            s.mean_run = '0;
            s.longest  = '0;
            if (seen_value) begin
                close_run();
                s.mean_run = total_len / run_cnt;
                s.longest  = longest_run;
            end
            summary_q.push_back(s);
            clear_stats();
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_summary(logic [31:0] mean_run, logic [31:0] longest, logic empty);
            run_summary_t want;
            summaries_seen++;
            if (summary_q.size() == 0) begin
                report($sformatf("unexpected result beat mean=%0d longest=%0d empty=%0b",
                                 mean_run, longest, empty));
                return;
            end
            want = summary_q.pop_front();
            if (mean_run !== want.mean_run)
                report($sformatf("average_per_slot got %0d want %0d", mean_run, want.mean_run));
            if (longest !== want.longest)
                report($sformatf("maximum_per_slot got %0d want %0d", longest, want.longest));
            if (empty !== want.empty)
                report($sformatf("no_records got %0b want %0b", empty, want.empty));
        endtask
    endclass

    // -----------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // -----------------------------------------------------------------------
    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [SKIP_WIDTH-1:0]  cfg_wr_data = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [BYTE_WIDTH-1:0]  s_tdata     = '0;   // [7:0] text_byte
    logic                   s_tlast     = 1'b0; // end_of_text
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [2*OUT_WIDTH-1:0] m_tdata;            // [31:0] average, [63:32] maximum
    logic                   m_tuser;            // [0] no_records

    int                 src_idle_pct  = 0;
    int                 sink_idle_pct = 0;
    int                 beats_sent    = 0;
    int                 cycle_count   = 0;
    bracket_run_tracker board;

    log_bracket_field_run_stats i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // 8 ns clock
    initial begin
        forever #4 aclk = ~aclk;
    end

    // Watchdog: a hung handshake or a missing result ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: sample the pre-edge handshake, then pick the next tready.
    // Reads in the active region see values from before this edge's updates.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_summary(m_tdata[31:0], m_tdata[63:32], m_tuser);
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // -----------------------------------------------------------------------
    // Drive tasks
    // -----------------------------------------------------------------------

    // One text beat: optional random gap, then hold tvalid until accepted.
    // Back-to-back beats keep tvalid high with a single assignment per edge.
    task automatic send_beat(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        board.note_byte(b, last);
        beats_sent++;
    endtask

    // Whole string as one text, tlast on its final character
    task automatic send_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_beat(s[i], i == s.len() - 1);
    endtask

    // Stop sending, wait for every queued summary, then let the divider drain
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.summary_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // skip_count write; only called with the block idle
    task automatic write_skip(input logic [SKIP_WIDTH-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        board.skip_cfg = v;
    endtask

    // 0: sender 22% / receiver 64%, 1: swapped, else no idling
    task automatic set_profile(input int p);
        case (p)
            0: begin
                src_idle_pct  = 22;
                sink_idle_pct = 64;
            end
            1: begin
                src_idle_pct  = 64;
                sink_idle_pct = 22;
            end
            default: begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
        endcase
    endtask

    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        return (b == CHAR_LBRACKET) ? CHAR_RBRACKET : b;
    endfunction

    function automatic logic [7:0] pick_space();
        int idx;
        idx = $urandom_range(5);
        return (idx == 5) ? CHAR_SPACE : CHAR_TAB + 8'(idx);
    endfunction

    // Number terminators: never a digit, never whitespace
    function automatic logic [7:0] pick_end();
        case ($urandom_range(4))
            0:       return 8'h2C;  // ','
            1:       return 8'h2D;  // '-'
            2:       return 8'h2B;  // '+'
            3:       return 8'h78;  // 'x'
            default: return CHAR_RBRACKET;
        endcase
    endfunction

    // One random text: mostly well-formed records with random content and
    // frequent repeats (so runs build up), plus raw noise, texts without any
    // record, and texts cut short inside a record.
    task automatic random_text();
        logic [7:0]      txt[$];
        int              kind;
        int              nrec;
        int              r;
        int              i;
        int              pick;
        int              cut;
        longint unsigned val;
        longint unsigned prev_val;
        string           digits;
        bit              chained;
        kind = $urandom_range(99);
        if (kind < 8) begin
            repeat ($urandom_range(1, 12)) txt.push_back(8'($urandom_range(255)));
        end else if (kind < 12) begin
            repeat ($urandom_range(1, 6)) txt.push_back(junk_byte());
        end else begin
            // long skips make long records: keep those texts short
            nrec     = $urandom_range(1, (board.skip_cfg > 16) ? 2 : 6);
            prev_val = $urandom_range(0, 9);
            chained  = 1'b0;
            for (r = 0; r < nrec; r++) begin
                if (!chained) begin
                    repeat ($urandom_range(0, 2)) txt.push_back(junk_byte());
                    txt.push_back(CHAR_LBRACKET);
                end
                // skipped bytes may hold anything, brackets included
                repeat (board.skip_cfg)
                    txt.push_back(($urandom_range(7) == 0) ? CHAR_LBRACKET
                                                           : 8'($urandom_range(255)));
                repeat ($urandom_range(0, 2)) txt.push_back(pick_space());
                pick = $urandom_range(99);
                if (pick < 8) begin
                    digits = "";   // no digits: reads as zero
                end else begin
                    if (pick < 60)
                        val = prev_val;
                    else if (pick < 85)
                        val = $urandom_range(0, 20);
                    else if (pick < 95)
                        val = $urandom_range(0, 99999);
                    else
                        val = $urandom_range(100000, 9999999);   // saturates
                    prev_val = val;
                    digits   = $sformatf("%0d", val);
                    if ($urandom_range(9) == 0)
                        digits = {"0", digits};
                end
                for (i = 0; i < digits.len(); i++)
                    txt.push_back(digits[i]);
                // a '[' right after the number opens the next record
                chained = ($urandom_range(5) == 0);
                txt.push_back(chained ? CHAR_LBRACKET : pick_end());
            end
            if ($urandom_range(4) == 0) begin
                cut = $urandom_range(1, txt.size() - 1);
                repeat (cut) void'(txt.pop_back());
            end
        end
        for (i = 0; i < txt.size(); i++)
            send_beat(txt[i], i == txt.size() - 1);
    endtask

    function automatic logic [SKIP_WIDTH-1:0] segment_skip(input int seg);
        case (seg)
            0:       return 6'd63;
            1:       return 6'd0;
            2:       return 6'($urandom_range(1, 7));
            3:       return 6'($urandom_range(0, 63));
            4:       return SKIP_RESET;
            default: return 6'd1;
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin
        int seg;
        int seg_beats;
        int seg_results;
        board = new();
        set_profile(0);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, skip 0: whitespace before a number, '[' ending a number,
        // a sign as first byte (no digits), a saturating number.
        write_skip(6'd0);
        send_str("[ \t7[7[-[999999]");
        // single-byte texts: extremes of the byte, no records at all
        send_beat(8'h00, 1'b1);
        send_beat(8'hFF, 1'b1);
        // text ending inside a number, and inside the whitespace phase
        send_str("[42");
        send_str("[");
        settle();
        // skipped bytes are brackets; number cut short by tlast
        write_skip(6'd2);
        send_str("[[[3");
        settle();

        // Random segments: new skip_count each, new back-pressure profile every two
        for (seg = 0; seg < NUM_SEGMENTS; seg++) begin
            set_profile(seg / 2);
            write_skip(segment_skip(seg));
            seg_beats   = beats_sent;
            seg_results = board.summaries_seen;
            while (beats_sent - seg_beats < SEG_BEATS ||
                   board.summaries_seen - seg_results < SEG_RESULTS)
                random_text();
            settle();
        end

        if (board.mismatches == 0 && board.summary_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
